// File: sv/sbp_pkg.sv
// ----------------------------------------------------------------------------
// sbp_pkg: shared types and constants of the SSH banner parser
// Byte classes, status codes, parse phase codes and the beat/result structs.
// ----------------------------------------------------------------------------
package sbp_pkg;

    // Fixed widths of the stream and result fields
    localparam int DATA_W   = 8;
    localparam int CLASS_W  = 3;
    localparam int STATUS_W = 2;
    localparam int LEN_W    = 16;
    localparam int PHASE_W  = 3;
    localparam int POS_W    = 3;

    // Defaults of the top-level parameters
    localparam int DEF_LENGTH_BITS      = 16;
    localparam int DEF_MIN_BANNER_BYTES = 8;

    // Byte classes
    localparam logic [CLASS_W-1:0] CLS_PREFIX   = 3'd0;
    localparam logic [CLASS_W-1:0] CLS_PROTO    = 3'd1;
    localparam logic [CLASS_W-1:0] CLS_SOFT     = 3'd2;
    localparam logic [CLASS_W-1:0] CLS_COMMENT  = 3'd3;
    localparam logic [CLASS_W-1:0] CLS_SEP      = 3'd4;
    localparam logic [CLASS_W-1:0] CLS_IGNORE   = 3'd5;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_TRUNC     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MALFORMED = 2'd2;

    // Parse phases (field phases share their code with the byte class)
    localparam logic [PHASE_W-1:0] PH_PREFIX   = 3'd0;
    localparam logic [PHASE_W-1:0] PH_PROTO    = 3'd1;
    localparam logic [PHASE_W-1:0] PH_SOFT     = 3'd2;
    localparam logic [PHASE_W-1:0] PH_COMMENT  = 3'd3;
    localparam logic [PHASE_W-1:0] PH_LINE_OK  = 3'd4;
    localparam logic [PHASE_W-1:0] PH_LINE_BAD = 3'd5;

    // Characters
    localparam logic [DATA_W-1:0] CH_LF    = 8'h0A;
    localparam logic [DATA_W-1:0] CH_CR    = 8'h0D;
    localparam logic [DATA_W-1:0] CH_DASH  = 8'h2D;
    localparam logic [DATA_W-1:0] CH_SPACE = 8'h20;

    // Number of prefix characters
    localparam logic [POS_W-1:0] PREFIX_LEN = 3'd4;

    // Expected character at each prefix position ("SSH-")
    function automatic logic [DATA_W-1:0] prefix_char(input logic [POS_W-1:0] pos);
        logic [DATA_W-1:0] ch;
        case (pos)
            3'd0:    ch = 8'h53;
            3'd1:    ch = 8'h53;
            3'd2:    ch = 8'h48;
            3'd3:    ch = CH_DASH;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // One stream beat
    typedef struct packed {
        logic [DATA_W-1:0] data_byte;
        logic              first_byte;
        logic              last_byte;
    } sbp_beat_t;

    // One result beat
    typedef struct packed {
        logic [CLASS_W-1:0]  byte_class;
        logic                decided;
        logic [STATUS_W-1:0] status;
        logic [LEN_W-1:0]    protocol_length;
        logic [LEN_W-1:0]    software_length;
        logic [LEN_W-1:0]    comment_length;
        logic [LEN_W-1:0]    consumed_length;
    } sbp_result_t;

endpackage

// File: sv/sbp_if.sv
// ----------------------------------------------------------------------------
// sbp_if: stream and result channels of the SSH banner parser
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface sbp_stream_if
    import sbp_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] data_byte;
    logic              first_byte;
    logic              last_byte;

    modport source (output valid, output data_byte, output first_byte,
                    output last_byte, input ready);
    modport sink   (input valid, input data_byte, input first_byte,
                    input last_byte, output ready);
endinterface

interface sbp_result_if
    import sbp_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [CLASS_W-1:0]  byte_class;
    logic                decided;
    logic [STATUS_W-1:0] status;
    logic [LEN_W-1:0]    protocol_length;
    logic [LEN_W-1:0]    software_length;
    logic [LEN_W-1:0]    comment_length;
    logic [LEN_W-1:0]    consumed_length;

    modport source (output valid, output byte_class, output decided, output status,
                    output protocol_length, output software_length,
                    output comment_length, output consumed_length, input ready);
    modport sink   (input valid, input byte_class, input decided, input status,
                    input protocol_length, input software_length,
                    input comment_length, input consumed_length, output ready);
endinterface

// File: sv/sbp_parser.sv
// ----------------------------------------------------------------------------
// sbp_parser: banner parse state and per-byte classification
// Holds the phase, prefix match position and saturating length counters;
// classifies one byte per enabled cycle and forms the result beat.
// ----------------------------------------------------------------------------
module sbp_parser
    import sbp_pkg::*;
#(
    parameter int LENGTH_BITS      = DEF_LENGTH_BITS,
    parameter int MIN_BANNER_BYTES = DEF_MIN_BANNER_BYTES
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step_en,
    input  sbp_beat_t   beat,
    output sbp_result_t res
);

    localparam logic [LENGTH_BITS-1:0] LMAX    = {LENGTH_BITS{1'b1}};
    localparam logic [LENGTH_BITS-1:0] MIN_LEN = LENGTH_BITS'(MIN_BANNER_BYTES);

    // Parse state
    logic [PHASE_W-1:0]     phase_reg, phase_next;
    logic [POS_W-1:0]       pos_reg, pos_next;
    logic                   pfail_reg, pfail_next;
    logic [LENGTH_BITS-1:0] bcount_reg, bcount_next;
    logic [LENGTH_BITS-1:0] proto_reg, proto_next;
    logic [LENGTH_BITS-1:0] soft_reg, soft_next;
    logic [LENGTH_BITS-1:0] comment_reg, comment_next;
    logic [LENGTH_BITS-1:0] line_reg, line_next;
    logic                   cr_reg, cr_next;
    logic                   lend_reg, lend_next;
    logic                   fin_reg, fin_next;

    // State as seen by this byte (a first byte restarts from reset values)
    logic [PHASE_W-1:0]     phase_c;
    logic [POS_W-1:0]       pos_c;
    logic                   pfail_c;
    logic [LENGTH_BITS-1:0] bcount_c, proto_c, soft_c, comment_c, line_c;
    logic                   cr_c, lend_c, fin_c;

    logic [1:0]             fld_inc;
    logic [LENGTH_BITS-1:0] fld_cur;
    logic [LENGTH_BITS:0]   fld_sum;
    logic [LENGTH_BITS-1:0] fld_new;
    logic [DATA_W-1:0]      b;

    assign b = beat.data_byte;

    // Restart on first byte
    always_comb
    begin
        if (beat.first_byte)
        begin
            phase_c   = PH_PREFIX;
            pos_c     = '0;
            pfail_c   = 1'b0;
            bcount_c  = '0;
            proto_c   = '0;
            soft_c    = '0;
            comment_c = '0;
            line_c    = '0;
            cr_c      = 1'b0;
            lend_c    = 1'b0;
            fin_c     = 1'b0;
        end
        else
        begin
            phase_c   = phase_reg;
            pos_c     = pos_reg;
            pfail_c   = pfail_reg;
            bcount_c  = bcount_reg;
            proto_c   = proto_reg;
            soft_c    = soft_reg;
            comment_c = comment_reg;
            line_c    = line_reg;
            cr_c      = cr_reg;
            lend_c    = lend_reg;
            fin_c     = fin_reg;
        end
    end

    // Field counter of the phase in progress
    always_comb
    begin
        case (phase_c)
            PH_PROTO:   fld_cur = proto_c;
            PH_SOFT:    fld_cur = soft_c;
            PH_COMMENT: fld_cur = comment_c;
            default:    fld_cur = '0;
        endcase
    end

    // Byte classification and next state
    always_comb
    begin
        phase_next   = phase_c;
        pos_next     = pos_c;
        pfail_next   = pfail_c;
        bcount_next  = bcount_c;
        proto_next   = proto_c;
        soft_next    = soft_c;
        comment_next = comment_c;
        line_next    = line_c;
        cr_next      = cr_c;
        lend_next    = lend_c;
        fin_next     = fin_c;
        fld_inc      = 2'd0;
        fld_sum      = '0;
        fld_new      = '0;
        res          = '0;
        res.byte_class = CLS_IGNORE;

        if (!fin_c)
        begin
            bcount_next = (bcount_c == LMAX) ? LMAX : bcount_c + 1'b1;
            if (!lend_c)
            begin
                line_next = (line_c == LMAX) ? LMAX : line_c + 1'b1;
                if (b == CH_LF)
                begin
                    lend_next = 1'b1;
                    cr_next   = 1'b0;
                    if (phase_c == PH_PREFIX || phase_c == PH_PROTO)
                        phase_next = PH_LINE_BAD;
                    else
                        phase_next = PH_LINE_OK;
                end
                else
                begin
                    // A held carriage return turned out not to end the line
                    fld_inc = {1'b0, cr_c};
                    cr_next = 1'b0;
                    if (phase_c == PH_PREFIX)
                    begin
                        if (!pfail_c)
                        begin
                            if (pos_c < PREFIX_LEN && b == prefix_char(pos_c))
                            begin
                                res.byte_class = CLS_PREFIX;
                                pos_next       = pos_c + 1'b1;
                                if (pos_c == PREFIX_LEN - 1'b1)
                                    phase_next = PH_PROTO;
                            end
                            else
                            begin
                                pfail_next = 1'b1;
                            end
                        end
                    end
                    else if (phase_c == PH_PROTO && b == CH_DASH)
                    begin
                        res.byte_class = CLS_SEP;
                        phase_next     = PH_SOFT;
                    end
                    else if (phase_c == PH_SOFT && b == CH_SPACE)
                    begin
                        res.byte_class = CLS_SEP;
                        phase_next     = PH_COMMENT;
                    end
                    else
                    begin
                        res.byte_class = phase_c;
                        if (b == CH_CR)
                            cr_next = 1'b1;
                        else
                            fld_inc = fld_inc + 2'd1;
                    end

                    // Saturating add of 0..2 to the field counter
                    fld_sum = {1'b0, fld_cur} + (LENGTH_BITS+1)'(fld_inc);
                    fld_new = fld_sum[LENGTH_BITS] ? LMAX : fld_sum[LENGTH_BITS-1:0];

                    case (phase_c)
                        PH_PROTO:   proto_next   = fld_new;
                        PH_SOFT:    soft_next    = fld_new;
                        PH_COMMENT: comment_next = fld_new;
                        default:    ;
                    endcase
                end
            end

            // Decision
            if (lend_next && bcount_next >= MIN_LEN)
            begin
                res.decided = 1'b1;
                fin_next    = 1'b1;
                if (phase_next == PH_LINE_BAD)
                begin
                    res.status = ST_MALFORMED;
                end
                else
                begin
                    res.status          = ST_OK;
                    res.protocol_length = LEN_W'(proto_next);
                    res.software_length = LEN_W'(soft_next);
                    res.comment_length  = LEN_W'(comment_next);
                    res.consumed_length = LEN_W'(line_next);
                end
            end
            else if (beat.last_byte)
            begin
                res.decided = 1'b1;
                res.status  = ST_TRUNC;
                fin_next    = 1'b1;
            end
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_PREFIX;
            pos_reg     <= '0;
            pfail_reg   <= 1'b0;
            bcount_reg  <= '0;
            proto_reg   <= '0;
            soft_reg    <= '0;
            comment_reg <= '0;
            line_reg    <= '0;
            cr_reg      <= 1'b0;
            lend_reg    <= 1'b0;
            fin_reg     <= 1'b0;
        end
        else if (step_en)
        begin
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            pfail_reg   <= pfail_next;
            bcount_reg  <= bcount_next;
            proto_reg   <= proto_next;
            soft_reg    <= soft_next;
            comment_reg <= comment_next;
            line_reg    <= line_next;
            cr_reg      <= cr_next;
            lend_reg    <= lend_next;
            fin_reg     <= fin_next;
        end
    end

endmodule

// File: sv/ssh_banner_parser_core.sv
// ----------------------------------------------------------------------------
// ssh_banner_parser_core: SSH identification line parser
// Classifies stream bytes and reports banner status and field lengths.
// ----------------------------------------------------------------------------
// Usage:
//   stream : one beat per stream byte (data_byte, first_byte, last_byte).
//            first_byte restarts parsing at that byte; last_byte marks the
//            end of the available data.
//   result : exactly one beat per stream beat, in order. byte_class tags the
//            byte; decided=1 on the beat that settles the banner, carrying
//            status and, if OK, protocol, software, comment, line lengths.
//   Path:    a stream beat passes the input register, then the parse step
//            into the result register.
//   Throughput: one byte per cycle while result is not stalled; the parse
//            state update is byte compares and saturating counter increments.
//   Reset: parse state returns to prefix matching, both pipeline registers
//            empty. When result is stalled the input register and result
//            register hold; stream.ready drops only when both are full.
// ----------------------------------------------------------------------------
module ssh_banner_parser_core
    import sbp_pkg::*;
#(
    parameter int LENGTH_BITS      = DEF_LENGTH_BITS,
    parameter int MIN_BANNER_BYTES = DEF_MIN_BANNER_BYTES
)(
    input  logic          clk,
    input  logic          rst_n,
    sbp_stream_if.sink    stream,
    sbp_result_if.source  result
);

    sbp_beat_t   in_reg;
    logic        in_valid_reg;
    sbp_result_t res_reg;
    logic        res_valid_reg;
    sbp_result_t step_res;
    logic        advance;
    logic        step_en;

    // Pipeline control
    assign advance      = !res_valid_reg || result.ready;
    assign step_en      = in_valid_reg && advance;
    assign stream.ready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (stream.valid && stream.ready)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (stream.valid && stream.ready)
        begin
            in_reg.data_byte  <= stream.data_byte;
            in_reg.first_byte <= stream.first_byte;
            in_reg.last_byte  <= stream.last_byte;
        end
    end

    // Parse step
    sbp_parser #(
        .LENGTH_BITS      (LENGTH_BITS),
        .MIN_BANNER_BYTES (MIN_BANNER_BYTES)
    ) u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (step_en),
        .beat    (in_reg),
        .res     (step_res)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (advance)
            res_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (step_en)
            res_reg <= step_res;
    end

    assign result.valid           = res_valid_reg;
    assign result.byte_class      = res_reg.byte_class;
    assign result.decided         = res_reg.decided;
    assign result.status          = res_reg.status;
    assign result.protocol_length = res_reg.protocol_length;
    assign result.software_length = res_reg.software_length;
    assign result.comment_length  = res_reg.comment_length;
    assign result.consumed_length = res_reg.consumed_length;

    // Checks
    a_err_no_len: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.decided && result.status != ST_OK
        |-> result.consumed_length == '0 && result.protocol_length == '0)
        else $error("error status with nonzero lengths");

    a_undecided_clear: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.decided
        |-> result.status == ST_OK && result.consumed_length == '0)
        else $error("undecided beat carries status or length");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !stream.ready |-> in_valid_reg && res_valid_reg && !result.ready)
        else $error("stream stalled with room in the pipeline");

    a_step_fills: assert property (@(posedge clk) disable iff (!rst_n)
        step_en |=> res_valid_reg)
        else $error("parse step lost its result");

endmodule
